FILE: hw/rtl/bfa_pkg.sv
package bfa_pkg;

    // Default sizing of the frame store
    localparam int DEF_NUM_FRAMES      = 4096;
    localparam int DEF_WORD_BITS       = 32;
    localparam int DEF_RESERVED_FRAMES = 16;

    // Width of the frame index fields on the ports
    localparam int FRAME_W = 12;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

FILE: hw/rtl/bitmap_frame_allocator.sv
// First-fit physical frame allocator. One bit per frame (1 = used) lives in a
// single-port-write, registered-read memory of NUM_FRAMES/WORD_BITS words,
// rounded up. After reset the block sweeps the memory, one word per cycle, to
// clear it and mark the lowest RESERVED_FRAMES frames used; input stays
// stalled until the sweep has covered every word. An allocate (command 0)
// reads words from index 0 upward, one per cycle, takes the lowest zero bit
// of the first word that has one, sets it and returns the frame number with
// found = 1; with no free frame it returns frame 0 and found = 0. Bits of the
// last word beyond NUM_FRAMES are never granted. A free (command 1) clears
// the named frame's bit without any check, echoes the index and returns
// found = 1; an index at or above NUM_FRAMES is echoed with found = 0 and
// leaves the store alone. One item is in work at a time: an allocate scans
// word by word until a hit or the last word, then forms the frame number
// (on a hit) and the result; a free steps through accept, index split and
// read, write back, result, and an out-of-range free goes straight from
// accept to result. A finished result waits until the output register is
// free. A finished result then sits in the output register, so the next
// item is taken while the previous result still waits for its transfer.
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES      = DEF_NUM_FRAMES,
    parameter int WORD_BITS       = DEF_WORD_BITS,
    parameter int RESERVED_FRAMES = DEF_RESERVED_FRAMES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [FRAME_W-1:0] i_frame_index,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FRAME_W-1:0] o_granted_frame,
    output logic               o_found
);

    localparam int NW        = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int FW        = $clog2(NW * WORD_BITS);
    localparam int XW        = (FW > FRAME_W) ? FW : FRAME_W;
    localparam int LAST_BITS = NUM_FRAMES - (NW - 1) * WORD_BITS;
    localparam int RS        = 20;
    localparam int RECIP     = (1 << RS) / WORD_BITS;

    localparam logic [AW-1:0]        LAST_ADDR = AW'(NW - 1);
    // Bits of the last word that lie past the end of the frame range
    localparam logic [WORD_BITS-1:0] TAIL_FILL = {WORD_BITS{1'b1}} << LAST_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FSPLIT,
        ST_FMOD,
        ST_AFRAME,
        ST_DONE
    } t_state;

    // Reset pattern of one bitmap word: reserved frames are used
    function automatic logic [WORD_BITS-1:0] init_word(input logic [AW-1:0] w);
        logic [WORD_BITS-1:0] v;
        v = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if ((int'(w) * WORD_BITS + b < RESERVED_FRAMES) &&
                (int'(w) * WORD_BITS + b < NUM_FRAMES)) begin
                v[b] = 1'b1;
            end
        end
        return v;
    endfunction

    t_state               r_state;
    logic [AW-1:0]        r_chk_addr;   // sweep, scan or target word
    logic [FRAME_W-1:0]   r_idx;
    logic [FRAME_W-1:0]   r_q;
    logic [BW-1:0]        r_bit;
    logic [FRAME_W-1:0]   r_res_frame;
    logic                 r_res_found;
    logic                 r_out_valid;
    logic [FRAME_W-1:0]   r_out_frame;
    logic                 r_out_found;

    logic [WORD_BITS-1:0] r_mem [NW];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [AW-1:0]        mem_rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    logic                 in_xfer;
    logic                 idx_in_range;
    logic [31:0]          q_prod;
    logic [FRAME_W-1:0]   q_est;
    logic [FRAME_W-1:0]   split_prod;
    logic [FRAME_W-1:0]   split_rem;
    logic [FRAME_W-1:0]   split_q;
    logic [FRAME_W-1:0]   split_r;
    logic [WORD_BITS-1:0] scan_word;
    logic                 scan_hit;
    logic [BW-1:0]        scan_bit;
    logic [WORD_BITS-1:0] scan_onehot;
    logic [XW-1:0]        alloc_frame;
    logic                 out_free;

    assign o_in_stall      = (r_state != ST_IDLE);
    assign in_xfer         = i_in_valid && !o_in_stall;
    assign o_out_valid     = r_out_valid;
    assign o_granted_frame = r_out_frame;
    assign o_found         = r_out_found;
    // Output register can take a new result this cycle
    assign out_free        = !r_out_valid || !i_out_stall;

    assign idx_in_range = (17'(i_frame_index) < 17'(NUM_FRAMES));

    // Word index of a freed frame: multiply by the reciprocal of WORD_BITS,
    // which may undershoot by one; the split stage corrects it.
    assign q_prod = 32'(i_frame_index) * 32'(RECIP);
    assign q_est  = q_prod[RS+FRAME_W-1:RS];

    always_comb begin
        split_prod = FRAME_W'(r_q * FRAME_W'(WORD_BITS));
        split_rem  = r_idx - split_prod;
        split_q    = r_q;
        split_r    = split_rem;
        if (split_rem >= FRAME_W'(WORD_BITS)) begin
            split_q = r_q + 1'b1;
            split_r = split_rem - FRAME_W'(WORD_BITS);
        end
    end

    // Scan check of the word that came back from memory
    always_comb begin
        scan_word = r_rd_data;
        if (r_chk_addr == LAST_ADDR) begin
            scan_word = r_rd_data | TAIL_FILL;
        end
        scan_hit = !(&scan_word);
        scan_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!scan_word[b]) begin
                scan_bit = BW'(b);
            end
        end
        scan_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << scan_bit;
    end

    assign alloc_frame = XW'(r_chk_addr) * XW'(WORD_BITS) + XW'(r_bit);

    // Memory port control
    always_comb begin
        mem_rd_addr = '0;
        mem_we      = 1'b0;
        mem_wdata   = r_rd_data;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = init_word(r_chk_addr);
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data | scan_onehot;
                end
                if (r_chk_addr != LAST_ADDR) begin
                    mem_rd_addr = r_chk_addr + 1'b1;
                end
            end
            ST_FSPLIT: begin
                mem_rd_addr = AW'(split_q);
            end
            ST_FMOD: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit);
            end
            ST_IDLE, ST_AFRAME, ST_DONE: begin
                mem_rd_addr = '0;
            end
            default: begin
                mem_rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_chk_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_chk_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once its transfer completes, unless a new one
            // is loaded in the same cycle
            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_chk_addr == LAST_ADDR) begin
                        r_chk_addr <= '0;
                        r_state    <= ST_IDLE;
                    end else begin
                        r_chk_addr <= r_chk_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_idx <= i_frame_index;
                        r_q   <= q_est;
                        if (i_command == CMD_ALLOC) begin
                            // word 0 read is issued this cycle
                            r_chk_addr <= '0;
                            r_state    <= ST_SCAN;
                        end else if (idx_in_range) begin
                            r_state <= ST_FSPLIT;
                        end else begin
                            r_res_frame <= i_frame_index;
                            r_res_found <= 1'b0;
                            r_state     <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    priority if (scan_hit) begin
                        r_bit   <= scan_bit;
                        r_state <= ST_AFRAME;
                    end else if (r_chk_addr == LAST_ADDR) begin
                        r_res_frame <= '0;
                        r_res_found <= 1'b0;
                        r_state     <= ST_DONE;
                    end else begin
                        r_chk_addr <= r_chk_addr + 1'b1;
                    end
                end
                ST_FSPLIT: begin
                    r_chk_addr <= AW'(split_q);
                    r_bit      <= BW'(split_r);
                    r_state    <= ST_FMOD;
                end
                ST_FMOD: begin
                    r_res_frame <= r_idx;
                    r_res_found <= 1'b1;
                    r_state     <= ST_DONE;
                end
                ST_AFRAME: begin
                    r_res_frame <= alloc_frame[FRAME_W-1:0];
                    r_res_found <= 1'b1;
                    r_state     <= ST_DONE;
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_frame <= r_res_frame;
                        r_out_found <= r_res_found;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/bfa_checker.sv
module bfa_checker
    import bfa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [FRAME_W-1:0] o_granted_frame,
    input logic               o_found
);

    // Reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Reset starts the store sweep, which holds off requests
    a_reset_stalls_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during store sweep");

    // One request in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_granted_frame) && $stable(o_found)))
        else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_granted_frame (o_granted_frame),
    .o_found         (o_found)
);
